FILE: rtl/sgf_pkg.sv
// Shared types, constants and helpers for the serial gap framer.
// No dependencies; imported by every module of the block.
package sgf_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = PTR_W + 1;

    localparam logic [2:0] CMD_RX   = 3'd0;
    localparam logic [2:0] CMD_TICK = 3'd1;
    localparam logic [2:0] CMD_POP  = 3'd2;
    localparam logic [2:0] CMD_REQ  = 3'd3;
    localparam logic [2:0] CMD_RESP = 3'd4;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_FRAME  = 2'd1;
    localparam logic [1:0] KIND_POP    = 2'd2;
    localparam logic [1:0] KIND_EMPTY  = 2'd3;

    localparam logic DEST_USS    = 1'b0;
    localparam logic DEST_MODBUS = 1'b1;

    localparam logic [1:0] REG_GAP      = 2'd0;
    localparam logic [1:0] REG_RESPONSE = 2'd1;
    localparam logic [1:0] REG_RECOVERY = 2'd2;
    localparam logic [1:0] REG_RETRY    = 2'd3;

    localparam int CFG_W = 16;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  rx_data;
        logic        rx_error;
        logic [31:0] cycle_now;
        logic        fmt_wait;
        logic        alt_drive_wait;
        logic        expect_uss;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       dest;
        logic [7:0] out_data;
        logic       last;
        logic       link_ready;
        logic       link_timeout;
        logic       link_aborted;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_status;
        logic load_byte;
    } ctrl_cmd_t;

    typedef struct packed {
        logic stream;
        logic remain_last;
        logic out_free;
    } dp_stat_t;

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] off);
        logic [PTR_W:0] sum;
        sum = {1'b0, p} + off;
        if (sum >= (PTR_W+1)'(BUFFER_DEPTH)) begin
            sum = sum - (PTR_W+1)'(BUFFER_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

FILE: rtl/sgf_ctrl.sv
// Sequencing state machine of the serial gap framer.
// Depends on sgf_pkg; drives sgf_datapath through ctrl_cmd_t.
module sgf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sgf_pkg::dp_stat_t  stat,
    output sgf_pkg::ctrl_cmd_t cmd
);
    import sgf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_RESP = 4'b0100,
        ST_LOAD = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.stream ? ST_LOAD : ST_RESP;
            end
            ST_RESP: begin
                if (stat.out_free) begin
                    cmd.load_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_LOAD: begin
                if (stat.out_free) begin
                    cmd.load_byte = 1'b1;
                    if (stat.remain_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/sgf_datapath.sv
// Datapath of the serial gap framer: byte buffer, gap timer, watchdog, result register.
// Depends on sgf_pkg; commanded by sgf_ctrl.
module sgf_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sgf_pkg::in_item_t        s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output sgf_pkg::out_item_t       m_data,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [sgf_pkg::CFG_W-1:0] cfg_wdata,
    input  sgf_pkg::ctrl_cmd_t       cmd,
    output sgf_pkg::dp_stat_t        stat
);
    import sgf_pkg::*;

    logic [7:0]       mem [BUFFER_DEPTH];
    logic [7:0]       rd_data_reg;

    logic [7:0]       gap_ticks_reg, gap_ticks_next;
    logic [15:0]      response_ticks_reg, response_ticks_next;
    logic [15:0]      recovery_ticks_reg, recovery_ticks_next;
    logic [3:0]       retry_limit_reg, retry_limit_next;

    in_item_t         item_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             got_bytes_reg, got_bytes_next;
    logic [31:0]      gap_deadline_reg, gap_deadline_next;
    logic             ready_reg, ready_next;
    logic             timeout_reg, timeout_next;
    logic             aborted_reg, aborted_next;
    logic [3:0]       retry_reg, retry_next;
    logic [32:0]      watch_deadline_reg, watch_deadline_next;
    logic             uss_waiting_reg, uss_waiting_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [1:0]       stream_kind_reg, stream_kind_next;
    logic             stream_dest_reg, stream_dest_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        out_reg, out_next;

    logic             mem_we;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             emit;
    logic             emit_dest;
    logic [32:0]      now_ext;
    logic [32:0]      watch_restart;
    logic [33:0]      recovery_deadline;
    logic             watch_expired;
    logic             stream_now;
    logic             remain_last;
    logic             out_free;

    assign now_ext           = {1'b0, item_reg.cycle_now};
    assign watch_restart     = now_ext + {17'd0, response_ticks_reg};
    assign recovery_deadline = {1'b0, watch_deadline_reg} + {18'd0, recovery_ticks_reg};
    assign watch_expired     = now_ext >= watch_deadline_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= item_reg.rx_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        out_reg          <= out_next;
        rd_ptr_reg       <= rd_ptr_next;
        stream_kind_reg  <= stream_kind_next;
        stream_dest_reg  <= stream_dest_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_ticks_reg      <= 8'd3;
            response_ticks_reg <= 16'd50;
            recovery_ticks_reg <= 16'd250;
            retry_limit_reg    <= 4'd1;
            head_reg           <= '0;
            count_reg          <= '0;
            got_bytes_reg      <= 1'b0;
            gap_deadline_reg   <= '0;
            ready_reg          <= 1'b1;
            timeout_reg        <= 1'b0;
            aborted_reg        <= 1'b0;
            retry_reg          <= '0;
            watch_deadline_reg <= '0;
            uss_waiting_reg    <= 1'b0;
            remain_reg         <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            gap_ticks_reg      <= gap_ticks_next;
            response_ticks_reg <= response_ticks_next;
            recovery_ticks_reg <= recovery_ticks_next;
            retry_limit_reg    <= retry_limit_next;
            head_reg           <= head_next;
            count_reg          <= count_next;
            got_bytes_reg      <= got_bytes_next;
            gap_deadline_reg   <= gap_deadline_next;
            ready_reg          <= ready_next;
            timeout_reg        <= timeout_next;
            aborted_reg        <= aborted_next;
            retry_reg          <= retry_next;
            watch_deadline_reg <= watch_deadline_next;
            uss_waiting_reg    <= uss_waiting_next;
            remain_reg         <= remain_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_comb begin
        gap_ticks_next      = gap_ticks_reg;
        response_ticks_next = response_ticks_reg;
        recovery_ticks_next = recovery_ticks_reg;
        retry_limit_next    = retry_limit_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_GAP:      gap_ticks_next      = cfg_wdata[7:0];
                REG_RESPONSE: response_ticks_next = cfg_wdata;
                REG_RECOVERY: recovery_ticks_next = cfg_wdata;
                REG_RETRY:    retry_limit_next    = cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        emit      = 1'b0;
        emit_dest = DEST_USS;
        if (count_reg != '0 && !got_bytes_reg &&
            item_reg.cycle_now >= gap_deadline_reg && !item_reg.fmt_wait) begin
            if (uss_waiting_reg) begin
                emit      = 1'b1;
                emit_dest = DEST_USS;
            end else if (!item_reg.alt_drive_wait) begin
                emit      = 1'b1;
                emit_dest = DEST_MODBUS;
            end
        end
    end

    always_comb begin
        head_next           = head_reg;
        count_next          = count_reg;
        got_bytes_next      = got_bytes_reg;
        gap_deadline_next   = gap_deadline_reg;
        ready_next          = ready_reg;
        timeout_next        = timeout_reg;
        aborted_next        = aborted_reg;
        retry_next          = retry_reg;
        watch_deadline_next = watch_deadline_reg;
        uss_waiting_next    = uss_waiting_reg;
        rd_ptr_next         = rd_ptr_reg;
        remain_next         = remain_reg;
        stream_kind_next    = stream_kind_reg;
        stream_dest_next    = stream_dest_reg;
        out_next            = out_reg;
        mem_we              = 1'b0;
        wr_addr             = ptr_add(head_reg, count_reg);
        rd_en               = 1'b0;
        rd_addr             = head_reg;
        stream_now          = 1'b0;

        if (cmd.exec) begin
            case (item_reg.cmd)
                CMD_RX: begin
                    if (!item_reg.rx_error && count_reg < CNT_W'(BUFFER_DEPTH)) begin
                        mem_we         = 1'b1;
                        count_next     = count_reg + 1'b1;
                        got_bytes_next = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (count_reg != '0 && got_bytes_reg) begin
                        gap_deadline_next = item_reg.cycle_now + {24'd0, gap_ticks_reg};
                    end
                    got_bytes_next = 1'b0;
                    if (emit) begin
                        stream_now       = 1'b1;
                        rd_en            = 1'b1;
                        rd_ptr_next      = ptr_inc(head_reg);
                        remain_next      = count_reg;
                        count_next       = '0;
                        stream_kind_next = KIND_FRAME;
                        stream_dest_next = emit_dest;
                        if (emit_dest == DEST_USS) begin
                            uss_waiting_next = 1'b0;
                        end
                    end
                    if (ready_reg) begin
                        retry_next          = '0;
                        timeout_next        = 1'b0;
                        aborted_next        = 1'b0;
                        watch_deadline_next = watch_restart;
                    end else if (watch_expired && !timeout_reg &&
                                 retry_reg < retry_limit_reg) begin
                        retry_next          = retry_reg + 1'b1;
                        timeout_next        = 1'b1;
                        watch_deadline_next = watch_restart;
                    end else if (watch_expired && retry_reg >= retry_limit_reg &&
                                 !aborted_reg) begin
                        aborted_next = 1'b1;
                    end else if ({1'b0, now_ext} >= recovery_deadline) begin
                        retry_next       = '0;
                        ready_next       = 1'b1;
                        timeout_next     = 1'b0;
                        aborted_next     = 1'b0;
                        uss_waiting_next = 1'b0;
                    end
                end
                CMD_POP: begin
                    if (count_reg != '0) begin
                        stream_now       = 1'b1;
                        rd_en            = 1'b1;
                        head_next        = ptr_inc(head_reg);
                        count_next       = count_reg - 1'b1;
                        remain_next      = CNT_W'(1);
                        stream_kind_next = KIND_POP;
                        stream_dest_next = DEST_USS;
                    end
                end
                CMD_REQ: begin
                    ready_next       = 1'b0;
                    uss_waiting_next = item_reg.expect_uss;
                end
                CMD_RESP: begin
                    ready_next = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (cmd.load_byte) begin
            out_next.kind     = stream_kind_reg;
            out_next.dest     = stream_dest_reg;
            out_next.out_data = rd_data_reg;
            out_next.last     = remain_last;
            remain_next       = remain_reg - 1'b1;
            if (!remain_last) begin
                rd_en       = 1'b1;
                rd_addr     = rd_ptr_reg;
                rd_ptr_next = ptr_inc(rd_ptr_reg);
            end
        end

        if (cmd.load_status) begin
            out_next.kind     = (item_reg.cmd == CMD_POP) ? KIND_EMPTY : KIND_STATUS;
            out_next.dest     = DEST_USS;
            out_next.out_data = '0;
            out_next.last     = 1'b1;
        end

        if (cmd.load_byte || cmd.load_status) begin
            out_next.link_ready   = ready_reg;
            out_next.link_timeout = timeout_reg;
            out_next.link_aborted = aborted_reg;
        end
    end

    always_comb begin
        if (cmd.load_byte || cmd.load_status) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign remain_last = (remain_reg == CNT_W'(1));
    assign out_free    = !m_valid_reg || m_ready;
    assign stat        = {stream_now, remain_last, out_free};
    assign m_valid     = m_valid_reg;
    assign m_data      = out_reg;

endmodule

FILE: rtl/serial_gap_framer_with_watchdog_top.sv
// A status or empty-pop result passes through EXEC and RESP, a popped byte or frame
// through EXEC and LOAD, and is loaded into the output register once it is free.
// One input beat at a time; frame bytes are paced by the buffer's single read port.
// Reset: aresetn is synchronous, active low; it empties the buffer, restores the
// register defaults and sets the link ready; buffer contents are not cleared.
// Top level of the serial gap framer; depends on sgf_pkg, sgf_ctrl, sgf_datapath.
module serial_gap_framer_with_watchdog_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  sgf_pkg::in_item_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output sgf_pkg::out_item_t        m_data,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [sgf_pkg::CFG_W-1:0] cfg_wdata
);
    import sgf_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    sgf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sgf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_status || cmd.load_byte) |-> stat.out_free)
        else $error("result loaded while output register occupied");

    a_single_load: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load_status && cmd.load_byte))
        else $error("status and byte loaded together");

    a_one_beat_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input beat accepted while previous beat in progress");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_status || cmd.load_byte) |=> m_valid)
        else $error("loaded result not presented");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for serial_gap_framer_with_watchdog_top: directed and random
// byte, tick, pop and watchdog traffic checked against an in-bench framer predictor.
// Depends on sgf_pkg and the RTL of the block; needs no files or arguments.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sgf_pkg::*;

    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam int         LONG_HOLD   = 400;
    localparam int         CYCLE_LIMIT = 20000000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_we    = 1'b0;
    logic [1:0]           cfg_index = REG_GAP;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    serial_gap_framer_with_watchdog_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // framer predictor state
    bit [7:0]        cfg_gap;
    bit [15:0]       cfg_resp;
    bit [15:0]       cfg_recov;
    bit [3:0]        cfg_retry_lim;
    bit [7:0]        rx_bytes[$];
    bit              got_bytes;
    bit [31:0]       gap_deadline;
    bit              link_ready;
    bit              link_timeout;
    bit              link_aborted;
    bit [3:0]        retries;
    longint unsigned watch_deadline;
    bit              uss_pending;

    out_item_t       pending_results[$];
    int              mismatches    = 0;
    int              counted_beats = 0;
    int unsigned     cycles        = 0;
    bit [31:0]       line_time     = 0;
    bit              tx_fast       = 1'b0;
    int              tx_calm       = 0;
    int              rx_stall      = 0;
    int              rx_calm       = 0;
    int              hold_asks     = 0;
    int              hold_served   = 0;
    int              hold_left     = 0;

    function automatic void reset_model();
        cfg_gap        = 8'd3;
        cfg_resp       = 16'd50;
        cfg_recov      = 16'd250;
        cfg_retry_lim  = 4'd1;
        rx_bytes.delete();
        got_bytes      = 1'b0;
        gap_deadline   = '0;
        link_ready     = 1'b1;
        link_timeout   = 1'b0;
        link_aborted   = 1'b0;
        retries        = '0;
        watch_deadline = 0;
        uss_pending    = 1'b0;
    endfunction

    function automatic void queue_result(logic [1:0] kind, logic dest, logic [7:0] data,
                                         logic last);
        out_item_t r;
        r.kind         = kind;
        r.dest         = dest;
        r.out_data     = data;
        r.last         = last;
        r.link_ready   = link_ready;
        r.link_timeout = link_timeout;
        r.link_aborted = link_aborted;
        pending_results.push_back(r);
    endfunction

    function automatic void step_watchdog(longint unsigned now);
        if (link_ready) begin
            retries        = '0;
            link_timeout   = 1'b0;
            link_aborted   = 1'b0;
            watch_deadline = now + cfg_resp;
        end else if (now >= watch_deadline && !link_timeout && retries < cfg_retry_lim) begin
            retries        = retries + 1'b1;
            link_timeout   = 1'b1;
            watch_deadline = now + cfg_resp;
        end else if (now >= watch_deadline && retries >= cfg_retry_lim && !link_aborted) begin
            link_aborted = 1'b1;
        end else if (now >= watch_deadline + cfg_recov) begin
            retries      = '0;
            link_ready   = 1'b1;
            link_timeout = 1'b0;
            link_aborted = 1'b0;
            uss_pending  = 1'b0;
        end
    endfunction

    function automatic void predict_results(in_item_t it);
        bit [7:0] burst[$];
        bit       emit;
        logic     to_dest;
        emit    = 1'b0;
        to_dest = DEST_USS;
        case (it.cmd)
            CMD_RX: begin
                if (!it.rx_error && rx_bytes.size() < BUFFER_DEPTH) begin
                    rx_bytes.push_back(it.rx_data);
                    got_bytes = 1'b1;
                end
            end
            CMD_TICK: begin
                if (rx_bytes.size() > 0) begin
                    if (got_bytes) begin
                        gap_deadline = it.cycle_now + cfg_gap;
                    end else if (it.cycle_now >= gap_deadline && !it.fmt_wait) begin
                        if (uss_pending) begin
                            emit        = 1'b1;
                            to_dest     = DEST_USS;
                            uss_pending = 1'b0;
                        end else if (!it.alt_drive_wait) begin
                            emit    = 1'b1;
                            to_dest = DEST_MODBUS;
                        end
                    end
                end
                got_bytes = 1'b0;
                if (emit) begin
                    burst = rx_bytes;
                    rx_bytes.delete();
                end
                step_watchdog(longint'(it.cycle_now));
                if (emit) begin
                    for (int i = 0; i < burst.size(); i++) begin
                        queue_result(KIND_FRAME, to_dest, burst[i], i == burst.size() - 1);
                    end
                    return;
                end
            end
            CMD_POP: begin
                if (rx_bytes.size() > 0) begin
                    queue_result(KIND_POP, DEST_USS, rx_bytes.pop_front(), 1'b1);
                end else begin
                    queue_result(KIND_EMPTY, DEST_USS, 8'h00, 1'b1);
                end
                return;
            end
            CMD_REQ: begin
                link_ready  = 1'b0;
                uss_pending = it.expect_uss;
            end
            CMD_RESP: begin
                link_ready = 1'b1;
            end
            default: begin
            end
        endcase
        queue_result(KIND_STATUS, DEST_USS, 8'h00, 1'b1);
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit [31:0] next_time(bit far);
        int unsigned span;
        span = far ? 2 * cfg_resp + cfg_recov + 2 : cfg_gap + 1;
        if ($urandom_range(0, 24) == 0) begin
            line_time = $urandom();
        end else begin
            line_time = line_time + $urandom_range(1, span);
        end
        return line_time;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it.cmd            = 3'($urandom_range(0, 7));
        it.rx_data        = 8'($urandom_range(0, 255));
        it.rx_error       = 1'($urandom_range(0, 1));
        it.cycle_now      = $urandom();
        it.fmt_wait       = 1'($urandom_range(0, 1));
        it.alt_drive_wait = 1'($urandom_range(0, 1));
        it.expect_uss     = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // output side: random stalls, calm stretches, long hold-off on request
    always @(posedge aclk) begin
        if (hold_asks != hold_served) begin
            hold_served <= hold_asks;
            hold_left   <= LONG_HOLD;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready = 1'b0;
        end else if (rx_stall > 0) begin
            m_ready  = 1'b0;
            rx_stall = rx_stall - 1;
        end else begin
            m_ready = 1'b1;
            if (rx_calm > 0) begin
                rx_calm = rx_calm - 1;
            end else if ($urandom_range(0, 2) == 0) begin
                rx_stall = pick_idle();
            end else if ($urandom_range(0, 59) == 0) begin
                rx_calm = $urandom_range(20, 80);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected beat kind=%0d dest=%0d data=%02h last=%0d",
                             $time, m_data.kind, m_data.dest, m_data.out_data, m_data.last);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_data.kind !== want.kind || m_data.dest !== want.dest ||
                    m_data.out_data !== want.out_data || m_data.last !== want.last ||
                    m_data.link_ready !== want.link_ready ||
                    m_data.link_timeout !== want.link_timeout ||
                    m_data.link_aborted !== want.link_aborted) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: expected kind=%0d dest=%0d data=%02h last=%0d rdy/to/ab=%0d%0d%0d",
                                 $time, want.kind, want.dest, want.out_data, want.last,
                                 want.link_ready, want.link_timeout, want.link_aborted);
                        $display("%0t: actual   kind=%0d dest=%0d data=%02h last=%0d rdy/to/ab=%0d%0d%0d",
                                 $time, m_data.kind, m_data.dest, m_data.out_data, m_data.last,
                                 m_data.link_ready, m_data.link_timeout, m_data.link_aborted);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_beat(in_item_t it);
        int idle;
        if (tx_fast || tx_calm > 0) begin
            idle = 0;
            if (tx_calm > 0) tx_calm--;
        end else begin
            idle = pick_idle();
            if ($urandom_range(0, 39) == 0) tx_calm = $urandom_range(10, 40);
        end
        @(negedge aclk);
        if (idle > 0) begin
            s_valid = 1'b0;
            repeat (idle) @(negedge aclk);
        end
        s_data  = it;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_results(it);
        counted_beats++;
    endtask

    task automatic send_cmd(logic [2:0] cmd);
        in_item_t it;
        it     = rand_item();
        it.cmd = cmd;
        send_beat(it);
    endtask

    task automatic send_byte(logic [7:0] data, logic err);
        in_item_t it;
        it          = rand_item();
        it.cmd      = CMD_RX;
        it.rx_data  = data;
        it.rx_error = err;
        send_beat(it);
    endtask

    task automatic send_tick(logic [31:0] now, logic fmt, logic alt);
        in_item_t it;
        it                = rand_item();
        it.cmd            = CMD_TICK;
        it.cycle_now      = now;
        it.fmt_wait       = fmt;
        it.alt_drive_wait = alt;
        send_beat(it);
    endtask

    task automatic send_request(logic uss);
        in_item_t it;
        it            = rand_item();
        it.cmd        = CMD_REQ;
        it.expect_uss = uss;
        send_beat(it);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val[CFG_W-1:0];
        @(posedge aclk);
        case (idx)
            REG_GAP:      cfg_gap       = val[7:0];
            REG_RESPONSE: cfg_resp      = val[15:0];
            REG_RECOVERY: cfg_recov     = val[15:0];
            REG_RETRY:    cfg_retry_lim = val[3:0];
            default: begin
            end
        endcase
    endtask

    task automatic set_config(int unsigned gap, int unsigned resp, int unsigned recov,
                              int unsigned lim);
        drain();
        write_reg(REG_GAP, gap);
        write_reg(REG_RESPONSE, resp);
        write_reg(REG_RECOVERY, recov);
        write_reg(REG_RETRY, lim);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic run_traffic(int target);
        int goal;
        int n;
        goal = counted_beats + target;
        while (counted_beats < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    if ($urandom_range(0, 2) == 0) send_request(1'($urandom_range(0, 1)));
                    n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                     : $urandom_range(1, 6);
                    repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                    repeat ($urandom_range(2, 6)) begin
                        send_tick(next_time($urandom_range(0, 7) == 0),
                                  $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
                    end
                    if ($urandom_range(0, 3) == 0) send_cmd(CMD_POP);
                end
                5, 6: begin
                    send_request(1'($urandom_range(0, 1)));
                    repeat ($urandom_range(2, 8)) send_tick(next_time(1'b1), 1'b0, 1'b0);
                    if ($urandom_range(0, 1) == 0) begin
                        send_cmd(CMD_RESP);
                        send_tick(next_time(1'b0), 1'b0, 1'b0);
                    end
                end
                7: begin
                    repeat ($urandom_range(1, 3)) send_cmd(CMD_POP);
                end
                default: begin
                    repeat ($urandom_range(1, 3)) send_beat(rand_item());
                end
            endcase
        end
    endtask

    task automatic test_directed_framing();
        send_cmd(CMD_POP);
        send_cmd(CMD_SPARE_5);
        send_cmd(CMD_SPARE_6);
        send_cmd(CMD_SPARE_7);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_tick(32'hFFFF_FFFE, 1'b0, 1'b0);
        send_tick(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_tick(32'd5, 1'b0, 1'b1);
        send_cmd(CMD_POP);
        send_request(1'b1);
        send_tick(32'd6, 1'b0, 1'b0);
        send_cmd(CMD_RESP);
        send_tick(32'd7, 1'b0, 1'b0);
    endtask

    task automatic test_watchdog_retries();
        set_config(3, 4, 6, 2);
        send_request(1'b0);
        send_tick(32'd100, 1'b0, 1'b0);
        send_tick(32'd102, 1'b0, 1'b0);
        send_tick(32'd104, 1'b0, 1'b0);
        send_tick(32'd110, 1'b0, 1'b0);
        set_config(3, 4, 6, 0);
        send_request(1'b0);
        send_tick(32'd130, 1'b0, 1'b0);
        send_tick(32'd140, 1'b0, 1'b0);
        line_time = 32'd200;
    endtask

    task automatic test_default_settings();
        set_config(3, 50, 250, 1);
        run_traffic(100);
    endtask

    task automatic test_output_backpressure();
        @(negedge aclk);
        hold_asks++;
        tx_fast = 1'b1;
        repeat (40) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_tick(next_time(1'b0), 1'b0, 1'b0);
        tx_fast = 1'b0;
        repeat (4) send_tick(next_time(1'b0), 1'b0, 1'b0);
    endtask

    task automatic test_min_settings();
        set_config(1, 1, 0, 0);
        run_traffic(100);
    endtask

    task automatic test_max_settings();
        set_config(255, 65535, 65535, 15);
        run_traffic(90);
    endtask

    task automatic test_random_settings();
        set_config($urandom_range(1, 255), $urandom_range(1, 400), $urandom_range(0, 400),
                   $urandom_range(0, 15));
        run_traffic(100);
    endtask

    initial begin
        reset_model();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed_framing();
        test_watchdog_retries();
        test_default_settings();
        test_output_backpressure();
        test_min_settings();
        test_max_settings();
        test_random_settings();
        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
